/* sv/rgb5551_box_downsample_assert.svh */
// Assertion macros used by the checker file of the downsampler.
`ifndef RGB5551_BOX_DOWNSAMPLE_ASSERT_SVH
`define RGB5551_BOX_DOWNSAMPLE_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define RBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define RBD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/rbd_pkg.sv */
package rbd_pkg;

  localparam int MaxOutWidth  = 2048;
  localparam int MaxOutHeight = 4096;
  localparam int AddrW        = $clog2(MaxOutWidth);
  localparam int HgtW         = $clog2(MaxOutHeight);
  localparam int WidthW       = 12;
  localparam int HeightW      = 13;
  localparam int ColW         = AddrW + 1;
  localparam int RowW         = HgtW + 1;
  localparam int PixW         = 16;
  localparam int ChW          = 5;
  localparam int PairW        = ChW + 1;
  localparam int QuadW        = ChW + 2;
  localparam int RedPos       = 11;
  localparam int GreenPos     = 6;
  localparam int BluePos      = 1;
  localparam int AvgShift     = 2;
  localparam int CfgDataW     = HeightW;

  typedef enum logic [0:0] {
    CfgOutWidth  = 1'b0,
    CfgOutHeight = 1'b1
  } cfg_idx_e;

  // Per-channel sums of a horizontal pixel pair, one line store entry.
  typedef struct packed {
    logic [PairW-1:0] r;
    logic [PairW-1:0] g;
    logic [PairW-1:0] b;
  } pair_sum_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    pair_sum_t        wdata;
  } mem_req_t;

  // What the front end hands to the averaging stage with each request.
  typedef struct packed {
    logic      valid;
    logic      last;
    pair_sum_t now;
  } front_t;

  function automatic pair_sum_t pair_sums(input logic [PixW-1:0] p,
                                          input logic [PixW-1:0] q);
    pair_sum_t s;
    s.r = {1'b0, p[RedPos +: ChW]}   + {1'b0, q[RedPos +: ChW]};
    s.g = {1'b0, p[GreenPos +: ChW]} + {1'b0, q[GreenPos +: ChW]};
    s.b = {1'b0, p[BluePos +: ChW]}  + {1'b0, q[BluePos +: ChW]};
    return s;
  endfunction

endpackage

/* sv/rgb5551_box_downsample.sv */
// 2x2 box-filter mipmap step for 5-5-5-1 pixels.
// Source pixels enter on the s_axis channel in raster order, for an image of
// 2*out_width columns by 2*out_height rows. One averaged pixel leaves on the
// m_axis channel per 2x2 block, with tlast on the last pixel of the frame.
// The block takes one source pixel per cycle while s_axis_tready is high. The
// request that carries the bottom-right pixel of a block is registered in the
// averaging stage along with the line store read, then in the output register.
// The line store is one single-port-write, one-read memory of 2048 entries;
// even source rows write pair sums, odd rows read them back a row later.
// Configuration writes (index 0 out_width, index 1 out_height) take effect at
// once and restart the frame; write them only while the block is idle.
// Reset sets both sizes to one and restarts the frame; the line store is not
// cleared since every entry is written before it is read within a frame.
// When m_axis_tready is low the result is held in the output register; one
// more result can wait in the averaging stage, and s_axis_tready drops only
// when both are full.
module rgb5551_box_downsample (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rbd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rbd_pkg::PixW-1:0]      s_axis_tdata,   // [15:0] src_pixel
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rbd_pkg::PixW-1:0]      m_axis_tdata,   // [15:0] out_pixel
  output logic                          m_axis_tlast    // frame_last
);

  rbd_pkg::mem_req_t  mem_req;
  rbd_pkg::front_t    front;
  rbd_pkg::pair_sum_t prev;
  logic               accept;
  logic               s2_adv;

  logic                     s2_valid_q, s2_valid_d;
  logic                     s2_last_q;
  rbd_pkg::pair_sum_t       s2_now_q;
  logic                     out_valid_q, out_valid_d;
  logic [rbd_pkg::PixW-1:0] out_pixel_q;
  logic                     out_last_q;

  logic [rbd_pkg::QuadW-1:0] sum_r, sum_g, sum_b;
  logic [rbd_pkg::PixW-1:0]  avg_pixel;

  assign s2_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s2_valid_q || s2_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rbd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (rbd_pkg::cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .pixel_i    (s_axis_tdata),
    .mem_req_o  (mem_req),
    .front_o    (front)
  );

  rbd_line_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (prev)
  );

  assign sum_r = {1'b0, s2_now_q.r} + {1'b0, prev.r};
  assign sum_g = {1'b0, s2_now_q.g} + {1'b0, prev.g};
  assign sum_b = {1'b0, s2_now_q.b} + {1'b0, prev.b};

  assign avg_pixel = {sum_r[rbd_pkg::AvgShift +: rbd_pkg::ChW],
                      sum_g[rbd_pkg::AvgShift +: rbd_pkg::ChW],
                      sum_b[rbd_pkg::AvgShift +: rbd_pkg::ChW],
                      1'b0};

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (accept) begin
      s2_valid_d = front.valid;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s2_valid_q && s2_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_last_q <= front.last;
      s2_now_q  <= front.now;
    end
    if (s2_valid_q && s2_adv) begin
      out_pixel_q <= avg_pixel;
      out_last_q  <= s2_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pixel_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* sv/rbd_line_store.sv */
module rbd_line_store (
  input  logic                clk_i,
  input  rbd_pkg::mem_req_t   req_i,
  output rbd_pkg::pair_sum_t  rdata_o
);

  rbd_pkg::pair_sum_t mem_q [rbd_pkg::MaxOutWidth];
  rbd_pkg::pair_sum_t rdata_q;

  // Read data only changes on a read, so a stalled consumer keeps its entry.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rbd_front.sv */
module rbd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  rbd_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [rbd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          accept_i,
  input  logic [rbd_pkg::PixW-1:0]      pixel_i,
  output rbd_pkg::mem_req_t             mem_req_o,
  output rbd_pkg::front_t               front_o
);

  logic [rbd_pkg::AddrW-1:0]   wm1_q, wm1_d;
  logic [rbd_pkg::HgtW-1:0]    hm1_q, hm1_d;
  logic [rbd_pkg::ColW-1:0]    col_q, col_d;
  logic [rbd_pkg::RowW-1:0]    row_q, row_d;
  logic [rbd_pkg::PixW-1:0]    left_q, left_d;
  logic [rbd_pkg::WidthW-1:0]  wval;
  logic [rbd_pkg::HeightW-1:0] hval;
  logic                        restart;
  logic                        col_end;
  logic                        row_end;
  rbd_pkg::pair_sum_t          now;

  assign wval = cfg_data_i[rbd_pkg::WidthW-1:0];
  assign hval = cfg_data_i;

  // Sizes are kept as (effective size - 1); zero acts as one, oversize clamps.
  always_comb begin
    wm1_d   = wm1_q;
    hm1_d   = hm1_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rbd_pkg::CfgOutWidth: begin
          restart = 1'b1;
          if (wval == '0) begin
            wm1_d = '0;
          end else if (wval > rbd_pkg::WidthW'(rbd_pkg::MaxOutWidth)) begin
            wm1_d = rbd_pkg::AddrW'(rbd_pkg::MaxOutWidth - 1);
          end else begin
            wm1_d = rbd_pkg::AddrW'(wval - 1'b1);
          end
        end
        rbd_pkg::CfgOutHeight: begin
          restart = 1'b1;
          if (hval == '0) begin
            hm1_d = '0;
          end else if (hval > rbd_pkg::HeightW'(rbd_pkg::MaxOutHeight)) begin
            hm1_d = rbd_pkg::HgtW'(rbd_pkg::MaxOutHeight - 1);
          end else begin
            hm1_d = rbd_pkg::HgtW'(hval - 1'b1);
          end
        end
        default: restart = 1'b0;
      endcase
    end
  end

  assign col_end = col_q[0] && (col_q[rbd_pkg::ColW-1:1] == wm1_q);
  assign row_end = row_q[0] && (row_q[rbd_pkg::RowW-1:1] == hm1_q);
  assign now     = rbd_pkg::pair_sums(left_q, pixel_i);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (restart) begin
      col_d  = '0;
      row_d  = '0;
      left_d = '0;
    end else if (accept_i) begin
      if (!col_q[0]) begin
        left_d = pixel_i;
      end
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q  <= '0;
      hm1_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else begin
      wm1_q  <= wm1_d;
      hm1_q  <= hm1_d;
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= left_d;
    end
  end

  // Even rows store their pair sums; odd rows read them back one row later.
  assign mem_req_o.we    = accept_i && col_q[0] && !row_q[0];
  assign mem_req_o.re    = accept_i && col_q[0] && row_q[0];
  assign mem_req_o.addr  = col_q[rbd_pkg::ColW-1:1];
  assign mem_req_o.wdata = now;

  assign front_o.valid = col_q[0] && row_q[0];
  assign front_o.last  = col_end && row_end;
  assign front_o.now   = now;

endmodule

/* sv/rbd_checker.sv */
`include "rgb5551_box_downsample_assert.svh"

module rbd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rbd_pkg::PixW-1:0]      m_axis_tdata,
  input logic                          m_axis_tlast
);

  // A stalled result must not change.
  `RBD_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

  // A result that appears on an empty output came from an accepted source request.
  `RBD_ASSERT(a_out_origin, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "result without a source request")

  // The input is only held off while a result waits at the output.
  `RBD_ASSERT(a_ready_cause, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

  // The alpha bit of every result is zero.
  `RBD_ASSERT_NEVER(a_alpha_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0], "alpha bit set")

endmodule

bind rgb5551_box_downsample rbd_checker u_rbd_checker (.*);
